FILE: design/dctp_pkg.sv
// shared types, constants and latency figures for the disk collision time predictor
// no dependencies
`default_nettype none

package dctp_pkg;

  localparam int TIME_W = 32;
  localparam int DIV_QW = TIME_W;
  localparam int DIV_LAT = DIV_QW + 1;
  localparam int WALL_LAT = 1 + DIV_LAT;
  localparam logic [30:0] BOX_RESET = 31'd6553600;

  typedef enum logic [0:0] {
    REG_BOX_WIDTH  = 1'b0,
    REG_BOX_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] tval;
    logic              hit;
  } evt_t;

  typedef struct packed {
    evt_t pair;
    evt_t wall_x;
    evt_t wall_y;
  } res_t;

  // front end, two multiplier stages, disc stage, root, numerator, divider
  function automatic int pair_latency(int frac);
    return 6 + (65 + frac) + 1 + DIV_LAT;
  endfunction

endpackage

`default_nettype wire

FILE: design/dctp_delay.sv
// enabled shift line that keeps side data aligned with the arithmetic stages
// no dependencies
`default_nettype none

module dctp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) sr[i] <= '0;
    end else if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

`default_nettype wire

FILE: design/dctp_mul.sv
// two-stage unsigned wide multiplier built from four registered partial products
// no dependencies
`default_nettype none

module dctp_mul #(
  parameter int WA = 66,
  parameter int WB = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int LA = WA / 2;
  localparam int LB = WB / 2;
  localparam int HA = WA - LA;
  localparam int HB = WB - LB;
  localparam int PW = WA + WB;

  logic [LA+LB-1:0] pp_ll;
  logic [LA+HB-1:0] pp_lh;
  logic [HA+LB-1:0] pp_hl;
  logic [HA+HB-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[LA-1:0] * b[LB-1:0];
      pp_lh <= a[LA-1:0] * b[WB-1:LB];
      pp_hl <= a[WA-1:LA] * b[LB-1:0];
      pp_hh <= a[WA-1:LA] * b[WB-1:LB];
      p     <= PW'(pp_ll) + (PW'(pp_lh) << LB) + (PW'(pp_hl) << LA)
               + (PW'(pp_hh) << (LA + LB));
    end
  end

endmodule

`default_nettype wire

FILE: design/dctp_sqrt.sv
// pipelined integer square root, one result bit per stage
// no dependencies
`default_nettype none

module dctp_sqrt #(
  parameter int W = 162
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   rad,
  output logic [W/2-1:0] root
);

  localparam int N = W / 2;

  logic [W-1:0] rad_s  [1:N];
  logic [N:0]   rem_s  [1:N];
  logic [N-1:0] root_s [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] rad_i;
    logic [N:0]   rem_i;
    logic [N-1:0] root_i;
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_rest
      assign rad_i  = rad_s[k];
      assign rem_i  = rem_s[k];
      assign root_i = root_s[k];
    end

    always_comb begin
      rem_sh = {rem_i[N-1:0], rad_i[W-1:W-2]};
      trial  = {root_i, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1]  <= {rad_i[W-3:0], 2'b00};
        rem_s[k+1]  <= ge ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
        root_s[k+1] <= {root_i[N-2:0], ge};
      end
    end
  end

  assign root = root_s[N];

endmodule

`default_nettype wire

FILE: design/dctp_div.sv
// pipelined restoring divider with saturating quotient, one quotient bit per stage
// no dependencies
`default_nettype none

module dctp_div #(
  parameter int NW = 82,
  parameter int DW = 66,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q
);

  logic          sat0;
  logic [DW-1:0] rem0;
  logic [QW-1:0] lo0;
  logic [DW-1:0] den0;

  logic          sat_s [1:QW];
  logic [DW-1:0] rem_s [1:QW];
  logic [QW-1:0] lo_s  [1:QW];
  logic [DW-1:0] den_s [1:QW];
  logic [QW-1:0] q_s   [1:QW];

  // quotient overflows when the upper part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      sat0 <= (num >> QW) >= NW'(den);
      rem0 <= DW'(num >> QW);
      lo0  <= num[QW-1:0];
      den0 <= den;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          sat_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] lo_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] q_i;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign sat_i = sat0;
      assign rem_i = rem0;
      assign lo_i  = lo0;
      assign den_i = den0;
      assign q_i   = '0;
    end else begin : g_rest
      assign sat_i = sat_s[k];
      assign rem_i = rem_s[k];
      assign lo_i  = lo_s[k];
      assign den_i = den_s[k];
      assign q_i   = q_s[k];
    end

    always_comb begin
      rem_sh = {rem_i, lo_i[QW-1]};
      ge     = rem_sh >= {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_s[k+1] <= sat_i;
        rem_s[k+1] <= ge ? DW'(rem_sh - {1'b0, den_i}) : rem_sh[DW-1:0];
        lo_s[k+1]  <= {lo_i[QW-2:0], 1'b0};
        den_s[k+1] <= den_i;
        q_s[k+1]   <= {q_i[QW-2:0], ge};
      end
    end
  end

  assign q = sat_s[QW] ? '1 : q_s[QW];

endmodule

`default_nettype wire

FILE: design/dctp_wall.sv
// wall hit time along one axis: numerator setup stage followed by the divider
// depends on dctp_pkg, dctp_div, dctp_delay
`default_nettype none

module dctp_wall
  import dctp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [31:0] p,
  input  logic signed [31:0] v,
  input  logic [30:0]        r,
  input  logic [30:0]        lim,
  output evt_t               evt
);

  localparam int NumW = 33 + FRAC_BITS;

  logic [33:0]     n_pos;
  logic [33:0]     n_neg;
  logic [33:0]     n;
  logic            n_gt0;
  logic [31:0]     vmag;
  logic [NumW-1:0] num_q;
  logic [31:0]     den_q;
  logic            hit_q;
  logic            hit_d;
  logic [TIME_W-1:0] quo;

  always_comb begin
    n_pos = {3'b000, lim} - {3'b000, r} - {{2{p[31]}}, p};
    n_neg = {{2{p[31]}}, p} - {3'b000, r};
    n     = v[31] ? n_neg : n_pos;
    n_gt0 = !n[33] && (n != '0);
    vmag  = v[31] ? 32'(-v) : v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= n_gt0 ? {n[32:0], {FRAC_BITS{1'b0}}} : '0;
      den_q <= vmag;
      hit_q <= (v != '0);
    end
  end

  dctp_div #(.NW(NumW), .DW(32), .QW(TIME_W)) u_div (
    .clk (clk),
    .en  (en),
    .num (num_q),
    .den (den_q),
    .q   (quo)
  );

  dctp_delay #(.W(1), .N(DIV_LAT)) u_hit_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (hit_q),
    .q   (hit_d)
  );

  assign evt.hit  = hit_d;
  assign evt.tval = hit_d ? quo : '0;

endmodule

`default_nettype wire

FILE: design/dctp_pair.sv
// pair contact time: difference, product and discriminant stages, root, numerator, divider
// depends on dctp_pkg, dctp_mul, dctp_sqrt, dctp_div, dctp_delay
`default_nettype none

module dctp_pair
  import dctp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic [30:0]        a_radius,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic [30:0]        b_radius,
  output evt_t               evt
);

  localparam int RootW = 65 + FRAC_BITS;
  localparam int RadW  = 2 * RootW;
  localparam int NumW  = 66 + FRAC_BITS;

  // differences
  logic signed [32:0] dx, dy, ux, uy;
  logic [31:0]        s;
  // products
  logic signed [65:0] m_b1, m_b2, m_a1, m_a2, m_c1, m_c2;
  logic [63:0]        s2;
  // dot products
  logic [66:0]        b_c, cr_c;
  logic               bneg;
  logic [65:0]        nb, a, cm;
  logic [63:0]        s2_q;
  // wide products
  logic [129:0]       as2;
  logic [131:0]       cm2;
  logic               bneg_m;
  logic [65:0]        nb_m, a_m;
  // discriminant
  logic [132:0]       diff;
  logic               go;
  logic [129:0]       disc;
  logic [65:0]        nb_d, a_d;
  // root and numerator
  logic [RootW-1:0]   root;
  logic               go_r;
  logic [65:0]        nb_r, a_r;
  logic [NumW:0]      num_c;
  logic               num_ok;
  logic [NumW-1:0]    num_q;
  logic [65:0]        a_n;
  logic               hit_q;
  logic               hit_d;
  logic [TIME_W-1:0]  quo;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
      dy <= {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
      ux <= {b_vel_x[31], b_vel_x} - {a_vel_x[31], a_vel_x};
      uy <= {b_vel_y[31], b_vel_y} - {a_vel_y[31], a_vel_y};
      s  <= {1'b0, a_radius} + {1'b0, b_radius};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_b1 <= ux * dx;
      m_b2 <= uy * dy;
      m_a1 <= ux * ux;
      m_a2 <= uy * uy;
      m_c1 <= ux * dy;
      m_c2 <= uy * dx;
      s2   <= s * s;
    end
  end

  // the discriminant is a*s^2 minus the squared cross product
  always_comb begin
    b_c  = {m_b1[65], m_b1} + {m_b2[65], m_b2};
    cr_c = {m_c1[65], m_c1} - {m_c2[65], m_c2};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bneg <= b_c[66];
      nb   <= 66'(67'(0) - b_c);
      a    <= m_a1 + m_a2;
      cm   <= cr_c[66] ? 66'(67'(0) - cr_c) : cr_c[65:0];
      s2_q <= s2;
    end
  end

  dctp_mul #(.WA(66), .WB(64)) u_mul_as (
    .clk (clk),
    .en  (en),
    .a   (a),
    .b   (s2_q),
    .p   (as2)
  );

  dctp_mul #(.WA(66), .WB(66)) u_mul_cc (
    .clk (clk),
    .en  (en),
    .a   (cm),
    .b   (cm),
    .p   (cm2)
  );

  dctp_delay #(.W(133), .N(2)) u_mul_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({bneg, nb, a}),
    .q   ({bneg_m, nb_m, a_m})
  );

  assign diff = {3'b000, as2} - {1'b0, cm2};

  always_ff @(posedge clk) begin
    if (en) begin
      go   <= bneg_m && !diff[132];
      disc <= diff[129:0];
      nb_d <= nb_m;
      a_d  <= a_m;
    end
  end

  dctp_sqrt #(.W(RadW)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({disc, {(2 * FRAC_BITS){1'b0}}}),
    .root (root)
  );

  dctp_delay #(.W(133), .N(RootW)) u_root_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({go, nb_d, a_d}),
    .q   ({go_r, nb_r, a_r})
  );

  always_comb begin
    num_c  = {1'b0, nb_r, {FRAC_BITS{1'b0}}} - (NumW+1)'(root);
    num_ok = go_r && !num_c[NumW] && (num_c != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= num_ok ? num_c[NumW-1:0] : '0;
      a_n   <= a_r;
      hit_q <= num_ok;
    end
  end

  dctp_div #(.NW(NumW), .DW(66), .QW(TIME_W)) u_div (
    .clk (clk),
    .en  (en),
    .num (num_q),
    .den (a_n),
    .q   (quo)
  );

  dctp_delay #(.W(1), .N(DIV_LAT)) u_hit_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (hit_q),
    .q   (hit_d)
  );

  assign evt.hit  = hit_d && (quo != '0);
  assign evt.tval = evt.hit ? quo : '0;

endmodule

`default_nettype wire

FILE: design/disk_collision_time_predictor.sv
// Predicts, for each pair of disks A and B, the time until they touch and the times until
// A reaches the x and y walls of the configured box, all as unsigned Q16.16 saturating at
// the maximum. One item is taken per cycle while in_ready is high; most of the depth lies
// in the square root unit (65 + FRAC_BITS stages, one root bit each) and the 33-stage
// divider. A two-entry output stage lets one result wait at the output without a stall.
`default_nettype none

module disk_collision_time_predictor
  import dctp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic [30:0]        a_radius,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic [30:0]        b_radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        pair_time,
  output logic               pair_hit,
  output logic [31:0]        wall_x_time,
  output logic               wall_x_hit,
  output logic [31:0]        wall_y_time,
  output logic               wall_y_hit
);

  localparam int PairLat  = pair_latency(FRAC_BITS);
  localparam int WallSkew = PairLat - WALL_LAT;
  localparam int EvtW     = $bits(evt_t);

  logic [30:0] box_width;
  logic [30:0] box_height;
  logic        en;
  logic        pipe_valid;
  evt_t        pair_evt, wx_evt, wy_evt, wx_d, wy_d;
  res_t        res_c, res_q, skid_q;
  logic        skid_valid;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= BOX_RESET;
      box_height <= BOX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances while the skid entry is free
  assign en       = !skid_valid;
  assign in_ready = en;

  dctp_delay #(.W(1), .N(PairLat)) u_valid_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (in_valid),
    .q   (pipe_valid)
  );

  dctp_pair #(.FRAC_BITS(FRAC_BITS)) u_pair (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .a_pos_x  (a_pos_x),
    .a_pos_y  (a_pos_y),
    .a_vel_x  (a_vel_x),
    .a_vel_y  (a_vel_y),
    .a_radius (a_radius),
    .b_pos_x  (b_pos_x),
    .b_pos_y  (b_pos_y),
    .b_vel_x  (b_vel_x),
    .b_vel_y  (b_vel_y),
    .b_radius (b_radius),
    .evt      (pair_evt)
  );

  dctp_wall #(.FRAC_BITS(FRAC_BITS)) u_wall_x (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .p   (a_pos_x),
    .v   (a_vel_x),
    .r   (a_radius),
    .lim (box_width),
    .evt (wx_evt)
  );

  dctp_wall #(.FRAC_BITS(FRAC_BITS)) u_wall_y (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .p   (a_pos_y),
    .v   (a_vel_y),
    .r   (a_radius),
    .lim (box_height),
    .evt (wy_evt)
  );

  dctp_delay #(.W(2 * EvtW), .N(WallSkew)) u_wall_dly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({wx_evt, wy_evt}),
    .q   ({wx_d, wy_d})
  );

  assign res_c = '{pair: pair_evt, wall_x: wx_d, wall_y: wy_d};

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (pipe_valid) begin
        if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          res_q     <= res_c;
        end else begin
          skid_valid <= 1'b1;
          skid_q     <= res_c;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      res_q      <= skid_q;
      skid_valid <= 1'b0;
    end
  end

  assign pair_time   = res_q.pair.tval;
  assign pair_hit    = res_q.pair.hit;
  assign wall_x_time = res_q.wall_x.tval;
  assign wall_x_hit  = res_q.wall_x.hit;
  assign wall_y_time = res_q.wall_y.tval;
  assign wall_y_hit  = res_q.wall_y.hit;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output transfer pending");

  a_pair_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_q.pair.hit) |-> (res_q.pair.tval == '0))
    else $error("pair time nonzero without a hit");

  a_wall_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (!res_q.wall_x.hit || !res_q.wall_y.hit)) |->
    ((res_q.wall_x.hit || res_q.wall_x.tval == '0) &&
     (res_q.wall_y.hit || res_q.wall_y.tval == '0)))
    else $error("wall time nonzero without a hit");

endmodule

`default_nettype wire

FILE: tb/dctp_checker.sv
// checker for the disk collision time predictor: watches the config, input and result channels,
// predicts the pair and wall times of every accepted input transfer and compares each result
// depends on dctp_pkg and on the predictor's port list
`timescale 1ns / 1ps

module dctp_checker
  import dctp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic [30:0]        a_radius,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic [30:0]        b_radius,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        pair_time,
  input  logic               pair_hit,
  input  logic [31:0]        wall_x_time,
  input  logic               wall_x_hit,
  input  logic [31:0]        wall_y_time,
  input  logic               wall_y_hit,
  output int                 fail_count,
  output int                 pending
);

  localparam int FB = 16;
  localparam longint TMAX = 64'hFFFF_FFFF;

  logic [30:0] box_w, box_h;
  res_t        times_q[$];
  int          n_seen;

  assign pending = times_q.size();

  function automatic evt_t wall_event(longint p, longint v, longint r, longint lim);
    evt_t   e;
    longint n, d, q;
    e.tval = '0;
    e.hit  = 1'b0;
    if (v != 0) begin
      e.hit = 1'b1;
      if (v > 0) begin
        n = lim - r - p;
        d = v;
      end else begin
        n = p - r;
        d = -v;
      end
      if (n > 0) begin
        q = (n <<< FB) / d;
        e.tval = (q > TMAX) ? TMAX[31:0] : q[31:0];
      end
    end
    return e;
  endfunction

  function automatic evt_t pair_event(longint dxl, longint dyl, longint uxl, longint uyl,
                                      longint sl);
    evt_t               e;
    logic signed [255:0] dx, dy, ux, uy, s, b, a, c, disc, num;
    logic [255:0]        root, cand, sq, q;
    dx = dxl;
    dy = dyl;
    ux = uxl;
    uy = uyl;
    s  = sl;
    e.tval = '0;
    e.hit  = 1'b0;
    b = ux * dx + uy * dy;
    if (b < 0) begin
      a = ux * ux + uy * uy;
      c = dx * dx + dy * dy - s * s;
      disc = b * b - a * c;
      if (disc >= 0) begin
        root = '0;
        for (int i = 127; i >= 0; i--) begin
          cand = root;
          cand[i] = 1'b1;
          sq = cand * cand;
          if (sq <= (disc <<< (2 * FB))) root = cand;
        end
        num = ((-b) <<< FB) - $signed(root);
        if (num > 0) begin
          q = $unsigned(num) / $unsigned(a);
          if (q > TMAX) q = TMAX;
          if (q != 0) begin
            e.tval = q[31:0];
            e.hit  = 1'b1;
          end
        end
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in result %0d, %s: got %h, expected %h", n_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t r, want;
    if (rst) begin
      box_w <= BOX_RESET;
      box_h <= BOX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BOX_WIDTH) box_w <= cfg_data;
        else if (cfg_index == REG_BOX_HEIGHT) box_h <= cfg_data;
      end
      if (in_valid && in_ready) begin
        r.pair = pair_event(longint'(b_pos_x) - longint'(a_pos_x),
                            longint'(b_pos_y) - longint'(a_pos_y),
                            longint'(b_vel_x) - longint'(a_vel_x),
                            longint'(b_vel_y) - longint'(a_vel_y),
                            longint'(a_radius) + longint'(b_radius));
        r.wall_x = wall_event(longint'(a_pos_x), longint'(a_vel_x), longint'(a_radius),
                              longint'(box_w));
        r.wall_y = wall_event(longint'(a_pos_y), longint'(a_vel_y), longint'(a_radius),
                              longint'(box_h));
        times_q.insert(times_q.size(), r);
      end
      if (out_valid && out_ready) begin
        if (times_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected", '0, '0);
        end else begin
          want = times_q.pop_front();
          if (pair_hit !== want.pair.hit)
            report_mismatch("pair_hit", 32'(pair_hit), 32'(want.pair.hit));
          if (pair_time !== want.pair.tval)
            report_mismatch("pair_time", pair_time, want.pair.tval);
          if (wall_x_hit !== want.wall_x.hit)
            report_mismatch("wall_x_hit", 32'(wall_x_hit), 32'(want.wall_x.hit));
          if (wall_x_time !== want.wall_x.tval)
            report_mismatch("wall_x_time", wall_x_time, want.wall_x.tval);
          if (wall_y_hit !== want.wall_y.hit)
            report_mismatch("wall_y_hit", 32'(wall_y_hit), 32'(want.wall_y.hit));
          if (wall_y_time !== want.wall_y.tval)
            report_mismatch("wall_y_time", wall_y_time, want.wall_y.tval);
        end
        n_seen++;
      end
    end
  end

  initial begin
    fail_count = 0;
    n_seen = 0;
  end

endmodule

FILE: tb/tb_top.sv
// top of the disk collision time predictor testbench: clock, reset, stimulus and verdict
// depends on dctp_pkg, disk_collision_time_predictor and dctp_checker
`timescale 1ns / 1ps

module tb_top;
  import dctp_pkg::*;

  localparam int LAT = pair_latency(16);
  localparam int WATCH_LIMIT = 4000;

  logic               clk, rst;
  logic               cfg_valid, cfg_ready;
  cfg_reg_t           cfg_index;
  logic [30:0]        cfg_data;
  logic               in_valid, in_ready;
  logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
  logic signed [31:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
  logic [30:0]        a_radius, b_radius;
  logic               out_valid, out_ready;
  logic [31:0]        pair_time, wall_x_time, wall_y_time;
  logic               pair_hit, wall_x_hit, wall_y_hit;
  int                 fail_count, pending;
  bit                 calm, hold_req, held;
  int                 quiet;

  disk_collision_time_predictor dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index(cfg_index), .cfg_data,
    .in_valid, .in_ready, .a_pos_x, .a_pos_y, .a_vel_x, .a_vel_y, .a_radius,
    .b_pos_x, .b_pos_y, .b_vel_x, .b_vel_y, .b_radius,
    .out_valid, .out_ready, .pair_time, .pair_hit, .wall_x_time, .wall_x_hit,
    .wall_y_time, .wall_y_hit
  );

  dctp_checker chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index(cfg_index), .cfg_data,
    .in_valid, .in_ready, .a_pos_x, .a_pos_y, .a_vel_x, .a_vel_y, .a_radius,
    .b_pos_x, .b_pos_y, .b_vel_x, .b_vel_y, .b_radius,
    .out_valid, .out_ready, .pair_time, .pair_hit, .wall_x_time, .wall_x_hit,
    .wall_y_time, .wall_y_hit, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall bursts, one long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  task automatic send(input logic [31:0] apx, apy, avx, avy, input logic [30:0] ar,
                      input logic [31:0] bpx, bpy, bvx, bvy, input logic [30:0] br);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_pos_x <= apx; a_pos_y <= apy; a_vel_x <= avx; a_vel_y <= avy; a_radius <= ar;
    b_pos_x <= bpx; b_pos_y <= bpy; b_vel_x <= bvx; b_vel_y <= bvy; b_radius <= br;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
  endtask

  task automatic write_box(input cfg_reg_t idx, input logic [30:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] small_val(int span);
    int v;
    v = $urandom_range(0, span << 16);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // mostly approaching pairs inside the box, some full-range noise
  task automatic random_items(int count);
    logic [31:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
    logic [30:0] ar, br;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
      end else begin
        apx = $urandom_range(0, 100 << 16);
        apy = $urandom_range(0, 100 << 16);
        avx = ($urandom_range(0, 7) == 0) ? 0 : small_val(20);
        avy = ($urandom_range(0, 7) == 0) ? 0 : small_val(20);
        bpx = apx + small_val(30);
        bpy = apy + small_val(30);
        bvx = avx - (bpx - apx) / 8 + small_val(3);
        bvy = avy - (bpy - apy) / 8 + small_val(3);
        ar  = $urandom_range(0, 5 << 16);
        br  = $urandom_range(0, 5 << 16);
        send(apx, apy, avx, avy, ar, bpx, bpy, bvx, bvy, br);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    quiet = 0;
    cfg_valid = 1'b0;
    cfg_index = REG_BOX_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    {a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y} = '0;
    a_radius = '0;
    b_radius = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    // head-on approach
    send(10 << 16, 50 << 16, 1 << 16, 0, 1 << 16, 30 << 16, 50 << 16, -(1 << 16), 0, 1 << 16);
    // separating
    send(10 << 16, 50 << 16, -(1 << 16), 0, 1 << 16, 30 << 16, 50 << 16, 1 << 16, 0, 1 << 16);
    // perpendicular motion
    send(10 << 16, 50 << 16, 0, 1 << 16, 1 << 16, 30 << 16, 50 << 16, 0, -(1 << 16), 1 << 16);
    // miss: negative discriminant
    send(10 << 16, 10 << 16, 1 << 16, 0, 1 << 16, 30 << 16, 60 << 16, -(1 << 16), 0, 1 << 16);
    // already overlapping and approaching
    send(10 << 16, 10 << 16, 1 << 16, 0, 5 << 16, 12 << 16, 10 << 16, -(1 << 16), 0, 5 << 16);
    // contact below one lsb
    send(0, 0, 32'h7FFF_FFFF, 0, 0, 2, 0, 32'h8000_0000, 0, 0);
    // very slow, huge times
    send(50 << 16, 50 << 16, 1, -1, 0, 32'h7000_0000, 50 << 16, -1, 0, 0);
    send(1 << 16, 1 << 16, -1, 1, 0, 32'h9000_0000, 32'h9000_0000, 1, 1, 0);
    // past the walls
    send(200 << 16, -(5 << 16), 1 << 16, -(1 << 16), 1 << 16, 0, 0, 0, 0, 0);
    send(-(5 << 16), 200 << 16, -(1 << 16), 1 << 16, 1 << 16, 0, 0, 0, 0, 0);
    send(99 << 16, 1 << 16, 3 << 16, -(3 << 16), 1 << 16, 0, 0, 0, 0, 0);

    write_box(REG_BOX_WIDTH, '0);
    write_box(REG_BOX_HEIGHT, '0);
    send(10 << 16, 10 << 16, 1 << 16, -(1 << 16), 0, 12 << 16, 10 << 16, -1, 0, 0);
    send(-(10 << 16), -(10 << 16), 1 << 16, 1 << 16, 0, 0, 0, 0, 0, 0);
    random_items(150);

    write_box(REG_BOX_WIDTH, 31'h7FFF_FFFF);
    write_box(REG_BOX_HEIGHT, 31'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 1, 1, 0, 0, 0, 0, 0, 0);
    hold_req = 1'b1;
    random_items(400);

    write_box(REG_BOX_WIDTH, $urandom);
    write_box(REG_BOX_HEIGHT, $urandom);
    random_items(400);

    write_box(REG_BOX_WIDTH, BOX_RESET);
    write_box(REG_BOX_HEIGHT, 31'd1 << 16);
    random_items(500);
    calm = 1'b1;
    random_items(250);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: disk_collision_time_predictor.f
design/dctp_pkg.sv
design/dctp_delay.sv
design/dctp_mul.sv
design/dctp_sqrt.sv
design/dctp_div.sv
design/dctp_wall.sv
design/dctp_pair.sv
design/disk_collision_time_predictor.sv
tb/dctp_checker.sv
tb/tb_top.sv
